@@ design/anxb_pkg.sv @@
package anxb_pkg;

  // nal length counter width default and width of the length field
  localparam int LENGTH_BITS_DEF = 24;
  localparam int NAL_LEN_W       = 24;

  // result group queue
  localparam int GROUP_DEPTH = 4;
  localparam int GROUP_PTR_W = $clog2(GROUP_DEPTH);
  localparam int GROUP_CNT_W = $clog2(GROUP_DEPTH + 1);

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_NAL_END  = 2'd1;
  localparam logic [1:0] KIND_UNIT_END = 2'd2;

  // start code bytes
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_START = 8'h01;

  // irap nal type range
  localparam logic [5:0] IRAP_TYPE_LO = 6'd16;
  localparam logic [5:0] IRAP_TYPE_HI = 6'd23;

  localparam logic [1:0] ZERO_RUN_MAX  = 2'd3;
  localparam logic [7:0] NAL_COUNT_MAX = 8'hFF;

  // all results caused by one input byte, in order:
  // zeros, then data byte, then end of nal, then end of unit
  typedef struct packed {
    logic [2:0]           zeros;
    logic                 has_byte;
    logic [7:0]           data;
    logic                 first;
    logic [5:0]           ptype;
    logic                 has_end;
    logic [NAL_LEN_W-1:0] len;
    logic                 has_unit;
    logic                 irap;
    logic [7:0]           count;
  } anxb_group_t;

endpackage

@@ design/anxb_parse.sv @@
module anxb_parse
  import anxb_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        unit_last,
  input  logic        group_full,
  output logic        group_push,
  output anxb_group_t group
);

  logic                   in_valid_q;
  logic [7:0]             data_q;
  logic                   last_q;

  logic [1:0]             zero_run;
  logic                   inside_nal;
  logic [LENGTH_BITS-1:0] cur_length;
  logic [5:0]             cur_type;
  logic                   irap_seen;
  logic [7:0]             nal_count;

  logic                   advance;
  logic                   is_zero;
  logic                   is_start;
  logic [2:0]             nz_step;
  logic                   hb_step;
  logic [1:0]             zr_after;
  logic [2:0]             nz;
  logic                   hb;
  logic [2:0]             pcount;
  logic                   first;
  logic [5:0]             first_type;
  logic [5:0]             type_next;
  logic [LENGTH_BITS:0]   len_sum;
  logic [LENGTH_BITS-1:0] len_next;
  logic [LENGTH_BITS-1:0] len_pick;
  logic [LENGTH_BITS+NAL_LEN_W-1:0] len_wide;
  logic                   irap_next;
  logic [7:0]             count_next;
  logic                   has_end;
  logic [2:0]             total;

  assign advance  = in_valid_q && !group_full;
  assign in_stall = in_valid_q && group_full;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_q <= data_byte;
      last_q <= unit_last;
    end
  end

  // classify byte against the held-back zeros
  always_comb begin
    is_zero  = (data_q == BYTE_ZERO);
    is_start = (data_q == BYTE_START) && (zero_run >= 2'd2);
    nz_step  = 3'd0;
    hb_step  = 1'b0;
    zr_after = 2'd0;
    if (is_zero) begin
      if (zero_run < ZERO_RUN_MAX) begin
        zr_after = zero_run + 2'd1;
      end else begin
        zr_after = ZERO_RUN_MAX;
        nz_step  = 3'd1;
      end
    end else if (!is_start) begin
      nz_step = {1'b0, zero_run};
      hb_step = 1'b1;
    end
  end

  always_comb begin
    nz = nz_step + (last_q ? {1'b0, zr_after} : 3'd0);
    hb = hb_step;
    if (!inside_nal) begin
      nz = 3'd0;
      hb = 1'b0;
    end
    pcount     = nz + {2'b00, hb};
    first      = inside_nal && (pcount != 3'd0) && (cur_length == '0);
    first_type = (nz != 3'd0) ? 6'd0 : data_q[6:1];
    type_next  = first ? first_type : cur_type;
    len_sum    = {1'b0, cur_length} + {{(LENGTH_BITS-2){1'b0}}, pcount};
    len_next   = len_sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : len_sum[LENGTH_BITS-1:0];
    irap_next  = irap_seen ||
                 (first && (first_type >= IRAP_TYPE_LO) && (first_type <= IRAP_TYPE_HI));
    count_next = (first && (nal_count != NAL_COUNT_MAX)) ? nal_count + 8'd1 : nal_count;

    // a start code closes the previous nal, the last byte closes the open one
    if (is_start) begin
      has_end  = inside_nal && (cur_length != '0);
      len_pick = cur_length;
    end else begin
      has_end  = last_q && inside_nal && (len_next != '0);
      len_pick = len_next;
    end
    len_wide = {{NAL_LEN_W{1'b0}}, len_pick};

    group.zeros    = nz;
    group.has_byte = hb;
    group.data     = data_q;
    group.first    = first;
    group.ptype    = is_start ? cur_type : type_next;
    group.has_end  = has_end;
    group.len      = len_wide[NAL_LEN_W-1:0];
    group.has_unit = last_q;
    group.irap     = irap_next;
    group.count    = count_next;

    total      = nz + {2'b00, hb} + {2'b00, has_end} + {2'b00, last_q};
    group_push = advance && (total != 3'd0);
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run   <= 2'd0;
      inside_nal <= 1'b0;
      cur_length <= '0;
      cur_type   <= 6'd0;
      irap_seen  <= 1'b0;
      nal_count  <= 8'd0;
    end else if (advance) begin
      if (last_q) begin
        zero_run   <= 2'd0;
        inside_nal <= 1'b0;
        cur_length <= '0;
        cur_type   <= 6'd0;
        irap_seen  <= 1'b0;
        nal_count  <= 8'd0;
      end else if (is_start) begin
        zero_run   <= 2'd0;
        inside_nal <= 1'b1;
        cur_length <= '0;
        cur_type   <= 6'd0;
      end else begin
        zero_run   <= zr_after;
        cur_length <= len_next;
        cur_type   <= type_next;
        irap_seen  <= irap_next;
        nal_count  <= count_next;
      end
    end
  end

  a_group_size: assert property (@(posedge clk) disable iff (rst)
    group_push |-> total <= 3'd6)
    else $error("result group larger than six");

  a_unit_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && last_q) |=> (zero_run == 2'd0 && !inside_nal &&
                             cur_length == '0 && nal_count == 8'd0 && !irap_seen))
    else $error("state not cleared after end of unit");

  a_outside_empty: assert property (@(posedge clk) disable iff (rst)
    !inside_nal |-> (cur_length == '0 && nal_count == 8'd0))
    else $error("length or count grew outside a nal");

  a_first_has_payload: assert property (@(posedge clk) disable iff (rst)
    (group_push && group.first) |-> (group.has_byte || group.zeros != 3'd0))
    else $error("first flag on a group without payload");

endmodule

@@ design/anxb_group_fifo.sv @@
module anxb_group_fifo
  import anxb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  anxb_group_t din,
  output logic        full,
  input  logic        pop,
  output anxb_group_t dout,
  output logic        not_empty
);

  anxb_group_t            mem [GROUP_DEPTH];
  logic [GROUP_PTR_W-1:0] wr_ptr;
  logic [GROUP_PTR_W-1:0] rd_ptr;
  logic [GROUP_CNT_W-1:0] count;

  assign full      = (count == GROUP_CNT_W'(GROUP_DEPTH));
  assign not_empty = (count != '0);
  assign dout      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/anxb_expand.sv @@
module anxb_expand
  import anxb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  anxb_group_t          head,
  input  logic                 head_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           kind,
  output logic [7:0]           payload,
  output logic                 first_of_nal,
  output logic [5:0]           unit_type,
  output logic [NAL_LEN_W-1:0] nal_length,
  output logic                 unit_irap,
  output logic [7:0]           unit_nal_count,
  output logic                 last_result
);

  logic [2:0] idx;
  logic [2:0] end_pos;
  logic [2:0] total;
  logic       step;

  assign out_valid = head_valid;
  assign step      = head_valid && !out_stall;
  assign pop       = step && last_result;

  always_comb begin
    end_pos        = head.zeros + {2'b00, head.has_byte};
    total          = end_pos + {2'b00, head.has_end} + {2'b00, head.has_unit};
    last_result    = ((idx + 3'd1) == total);
    kind           = KIND_PAYLOAD;
    payload        = 8'd0;
    first_of_nal   = 1'b0;
    unit_type      = 6'd0;
    nal_length     = '0;
    unit_irap      = 1'b0;
    unit_nal_count = 8'd0;
    priority if (idx < head.zeros) begin
      first_of_nal = head.first && (idx == 3'd0);
      unit_type    = head.ptype;
    end else if (head.has_byte && (idx == head.zeros)) begin
      payload      = head.data;
      first_of_nal = head.first && (idx == 3'd0);
      unit_type    = head.ptype;
    end else if (head.has_end && (idx == end_pos)) begin
      kind       = KIND_NAL_END;
      unit_type  = head.ptype;
      nal_length = head.len;
    end else begin
      kind           = KIND_UNIT_END;
      unit_irap      = head.irap;
      unit_nal_count = head.count;
    end
  end

  // position within the current group
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 3'd0;
    end else if (step) begin
      idx <= last_result ? 3'd0 : idx + 3'd1;
    end
  end

endmodule

@@ design/annexb_nal_splitter_unit.sv @@
// path: a byte is caught in the input register, and its group record goes into the queue
// throughput: one byte per cycle while each byte causes at most one result and the output is
//   not stalled; the results of one byte come out in order, and a four-group queue absorbs bursts
// reset: synchronous, active high; clears parser state, queue pointers and group position
module annexb_nal_splitter_unit
  import anxb_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // byte input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           data_byte,
  input  logic                 unit_last,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           kind,
  output logic [7:0]           payload,
  output logic                 first_of_nal,
  output logic [5:0]           unit_type,
  output logic [NAL_LEN_W-1:0] nal_length,
  output logic                 unit_irap,
  output logic [7:0]           unit_nal_count,
  output logic                 last_result
);

  // the parser turns each byte that causes any result into one group record describing all of its results:
  // released zeros, the byte itself, an end of nal marker and an end of unit marker
  anxb_group_t group_in;
  anxb_group_t group_head;
  logic        group_push;
  logic        group_full;
  logic        group_pop;
  logic        group_valid;

  // input register, start code tracking and nal / unit bookkeeping
  anxb_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .unit_last  (unit_last),
    .group_full (group_full),
    .group_push (group_push),
    .group      (group_in)
  );

  // queue of group records, decouples parsing from result delivery
  anxb_group_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (group_push),
    .din       (group_in),
    .full      (group_full),
    .pop       (group_pop),
    .dout      (group_head),
    .not_empty (group_valid)
  );

  // walks the head group and hands out one result item per cycle while the output is not stalled
  anxb_expand u_expand (
    .clk            (clk),
    .rst            (rst),
    .head           (group_head),
    .head_valid     (group_valid),
    .pop            (group_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .payload        (payload),
    .first_of_nal   (first_of_nal),
    .unit_type      (unit_type),
    .nal_length     (nal_length),
    .unit_irap      (unit_irap),
    .unit_nal_count (unit_nal_count),
    .last_result    (last_result)
  );

endmodule

@@ dv/tb_annexb_nal_splitter_unit.sv @@
module tb_annexb_nal_splitter_unit;
  import anxb_pkg::*;

  // idle cycles with no item accepted on either side before the run is called hung
  localparam int WATCHDOG_LIMIT = 2000;
  // cycles to watch for stray results once nothing more is due
  localparam int DRAIN_CYCLES   = 20;
  // random items after the directed table
  localparam int RANDOM_ITEMS   = 175;

  // one result item as the splitter emits it
  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           payload;
    logic                 first;
    logic [5:0]           utype;
    logic [NAL_LEN_W-1:0] len;
    logic                 irap;
    logic [7:0]           count;
    logic                 last;
  } result_t;

  // one row of the directed table; typed rows carry their single result written out
  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       typed;
    result_t    want;
  } dir_row_t;

  // end of unit with no nal at all: count 0, irap 0, only result of its byte
  localparam result_t UNIT_EMPTY = '{kind: KIND_UNIT_END, last: 1'b1, default: '0};
  localparam result_t NO_EXP     = '0;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           data_byte = 8'h00;
  logic                 unit_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           kind;
  logic [7:0]           payload;
  logic                 first_of_nal;
  logic [5:0]           unit_type;
  logic [NAL_LEN_W-1:0] nal_length;
  logic                 unit_irap;
  logic [7:0]           unit_nal_count;
  logic                 last_result;

  // parser state mirrored by the predictor
  logic [1:0]           held_zeros;
  logic                 in_nal;
  logic [NAL_LEN_W-1:0] nal_len;
  logic [5:0]           cur_ty;
  logic                 irap_hit;
  logic [7:0]           nal_cnt;

  // results of the byte being parsed, then the queue of results still due
  result_t batch_q[$];
  result_t due_results[$];

  // both sides idle at random unless a calm stretch is on
  logic calm = 1'b0;
  int   stall_left = 0;
  int   idle_cycles = 0;

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int units_seen = 0;
  int nal_ends = 0;
  int irap_units = 0;

  // directed table: extremes, both start code lengths, the zero rules and empty nals
  dir_row_t dir_tab [29] = '{
    '{8'h55, 1'b1, 1'b1, UNIT_EMPTY},  // unit with no start code at all
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h01, 1'b0, 1'b0, NO_EXP},      // 3-byte start code
    '{8'h20, 1'b0, 1'b0, NO_EXP},      // header of an irap nal, type 16
    '{8'hFF, 1'b0, 1'b0, NO_EXP},
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h01, 1'b0, 1'b0, NO_EXP},      // 4-byte start code closes a 2-byte nal
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h01, 1'b0, 1'b0, NO_EXP},      // start code right after start code: empty nal
    '{8'h7E, 1'b0, 1'b0, NO_EXP},      // top type, 63
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h00, 1'b0, 1'b0, NO_EXP},      // fourth zero lets the oldest one out
    '{8'h02, 1'b0, 1'b0, NO_EXP},      // other byte flushes the held zeros first
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h01, 1'b0, 1'b0, NO_EXP},
    '{8'h00, 1'b0, 1'b0, NO_EXP},      // nal whose header byte is a zero
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h00, 1'b1, 1'b0, NO_EXP},      // zeros pending at the end: six results
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h00, 1'b0, 1'b0, NO_EXP},
    '{8'h01, 1'b1, 1'b1, UNIT_EMPTY}   // start code as the last bytes of a unit
  };

  annexb_nal_splitter_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .unit_last      (unit_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .payload        (payload),
    .first_of_nal   (first_of_nal),
    .unit_type      (unit_type),
    .nal_length     (nal_length),
    .unit_irap      (unit_irap),
    .unit_nal_count (unit_nal_count),
    .last_result    (last_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  task automatic clear_parser();
    held_zeros = '0;
    in_nal     = 1'b0;
    nal_len    = '0;
    cur_ty     = '0;
    irap_hit   = 1'b0;
    nal_cnt    = '0;
  endtask

  task automatic put_result(input logic [1:0] k, input logic [7:0] p, input logic f,
                            input logic [5:0] t, input logic [NAL_LEN_W-1:0] n,
                            input logic ir, input logic [7:0] c);
    result_t r;
    r = '{kind: k, payload: p, first: f, utype: t, len: n, irap: ir, count: c,
          last: 1'b0};
    batch_q = {batch_q, r};
  endtask

  // a payload byte: dropped before the first start code, else sent with the nal type
  task automatic emit_payload(input logic [7:0] b);
    logic f;
    if (in_nal) begin
      f = (nal_len == '0);
      if (f) begin
        cur_ty = b[6:1];
        if (cur_ty >= IRAP_TYPE_LO && cur_ty <= IRAP_TYPE_HI)
          irap_hit = 1'b1;
        if (nal_cnt != NAL_COUNT_MAX)
          nal_cnt = nal_cnt + 8'd1;
      end
      put_result(KIND_PAYLOAD, b, f, cur_ty, '0, 1'b0, 8'd0);
      // length counter holds at all ones
      if (nal_len != '1)
        nal_len = nal_len + 1'b1;
    end
  endtask

  task automatic flush_held();
    while (held_zeros != 2'd0) begin
      emit_payload(BYTE_ZERO);
      held_zeros = held_zeros - 2'd1;
    end
  endtask

  // empty nals end silently
  task automatic close_nal();
    if (in_nal && nal_len != '0)
      put_result(KIND_NAL_END, 8'd0, 1'b0, cur_ty, nal_len, 1'b0, 8'd0);
    nal_len = '0;
    cur_ty  = '0;
  endtask

  // all results that one accepted byte causes, in order, into batch_q
  task automatic parse_byte(input logic [7:0] b, input logic l);
    batch_q.delete();
    if (b == BYTE_ZERO) begin
      if (held_zeros != ZERO_RUN_MAX)
        held_zeros = held_zeros + 2'd1;
      else
        emit_payload(BYTE_ZERO);
    end else if (b == BYTE_START && held_zeros >= 2'd2) begin
      close_nal();
      in_nal     = 1'b1;
      held_zeros = '0;
    end else begin
      flush_held();
      emit_payload(b);
    end
    if (l) begin
      flush_held();
      close_nal();
      put_result(KIND_UNIT_END, 8'd0, 1'b0, 6'd0, '0, irap_hit, nal_cnt);
      clear_parser();
    end
    if (batch_q.size() != 0)
      batch_q[batch_q.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------- stimulus

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 2);
    else if (r < 97)
      return $urandom_range(3, 6);
    else
      return $urandom_range(10, 30);
  endfunction

  // zeros, 0x01 and 0x03 come often so that start codes form and break up
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3)
      return BYTE_ZERO;
    else if (r == 3)
      return BYTE_START;
    else if (r == 4)
      return 8'h03;
    else
      return 8'($urandom_range(0, 255));
  endfunction

  // nal header with types around the irap range half the time
  function automatic logic [7:0] pick_header();
    logic [7:0] h;
    h = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 1)
      h[6:1] = 6'($urandom_range(14, 25));
    return h;
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic push_byte(input logic [7:0] b, input logic l, input logic typed,
                           input result_t want);
    int gap;
    gap = pick_idle();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    unit_last <= l;
    do
      @(posedge clk);
    while (in_stall);
    items_sent++;
    parse_byte(b, l);
    if (typed)
      due_results = {due_results, want};
    else
      due_results = {due_results, batch_q};
    @(negedge clk);
  endtask

  // sender holds off until every due result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  // one access unit: mostly well formed nals with random content, some noise
  task automatic send_unit();
    logic [7:0] ub[$];
    int         nals;
    int         plen;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // noise unit, may or may not hold a start code
      repeat ($urandom_range(1, 6))
        ub = {ub, pick_byte()};
    end else begin
      // junk ahead of the first start code
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3))
          ub = {ub, pick_byte()};
      nals = $urandom_range(1, 4);
      repeat (nals) begin
        r = $urandom_range(0, 19);
        if (r < 9) begin
          ub = {ub, BYTE_ZERO, BYTE_ZERO};
        end else if (r < 18) begin
          ub = {ub, BYTE_ZERO, BYTE_ZERO, BYTE_ZERO};
        end else begin
          // broken start code, one zero short
          ub = {ub, BYTE_ZERO};
        end
        ub = {ub, BYTE_START};
        plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        if (plen != 0) begin
          ub = {ub, pick_header()};
          repeat (plen - 1)
            ub = {ub, pick_byte()};
        end
      end
      // trailing zeros left pending at the end
      if ($urandom_range(0, 6) == 0)
        repeat ($urandom_range(1, 4))
          ub = {ub, BYTE_ZERO};
      if (ub.size() == 0)
        ub = {ub, pick_byte()};
    end
    foreach (ub[i])
      push_byte(ub[i], (i == ub.size() - 1), 1'b0, NO_EXP);
  endtask

  // ---------------------------------------------------------------- main sequence

  initial begin
    int units;
    clear_parser();
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed table, fixed expectations where typed, predictor elsewhere
    foreach (dir_tab[i])
      push_byte(dir_tab[i].b, dir_tab[i].l, dir_tab[i].typed, dir_tab[i].want);
    wait_drained();

    // random units, some with no idling at all, a full drain now and then
    units = 0;
    while (items_sent < $size(dir_tab) + RANDOM_ITEMS) begin
      calm <= ($urandom_range(0, 4) == 0);
      send_unit();
      units++;
      if (units % 6 == 0)
        wait_drained();
    end
    calm <= 1'b0;

    in_valid <= 1'b0;
    while (due_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes giving %0d results: %0d access units, %0d nal ends",
             items_sent, results_seen, units_seen, nal_ends);
    $display("%0d units carried an irap nal, with empty nals, junk and pending zeros",
             irap_units);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- result side

  // random stall on the result channel, same idle mix as the sender
  always @(negedge clk) begin
    int len;
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      len = pick_idle();
      out_stall <= (len != 0);
      stall_left = (len != 0) ? len - 1 : 0;
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // every accepted result against the oldest one due
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (kind == KIND_NAL_END)
        nal_ends++;
      if (kind == KIND_UNIT_END) begin
        units_seen++;
        if (unit_irap)
          irap_units++;
      end
      if (due_results.size() == 0) begin
        $error("result item with nothing due: kind %0d payload %0d", kind, payload);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", want.kind, kind);
        check_field("payload", want.payload, payload);
        check_field("first_of_nal", want.first, first_of_nal);
        check_field("unit_type", want.utype, unit_type);
        check_field("nal_length", want.len, nal_length);
        check_field("unit_irap", want.irap, unit_irap);
        check_field("unit_nal_count", want.count, unit_nal_count);
        check_field("last_result", want.last, last_result);
      end
    end
  end

  // hang detector: too long with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
